/* sv/memory_card_frame_sequencer_core_defines.svh */
// ---------------------------------------------------------------------------
// Memory card frame sequencer assertion macros
// Shared property templates for the checker of the sequencer core.
// ---------------------------------------------------------------------------
`ifndef MEMORY_CARD_FRAME_SEQUENCER_CORE_DEFINES_SVH
`define MEMORY_CARD_FRAME_SEQUENCER_CORE_DEFINES_SVH

// Implication checked in the same cycle.
`define MCFS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the next cycle.
`define MCFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/mcfs_pkg.sv */
// ---------------------------------------------------------------------------
// Memory card frame sequencer package
// Frame layout constants, codes and shared types of the sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

package mcfs_pkg;

    localparam int SectorBytes = 128;
    localparam int IdxW        = $clog2(SectorBytes);
    localparam int PosW        = 8;
    localparam int IDataW      = 24;
    localparam int ODataW      = 40;

    localparam logic [7:0] CardId      = 8'h81;
    localparam logic [7:0] CmdRead     = 8'h52;
    localparam logic [7:0] CmdWrite    = 8'h57;
    localparam logic [7:0] IdleByte    = 8'h00;
    localparam logic [7:0] StGood      = 8'h47;
    localparam logic [7:0] StBadCsum   = 8'h4E;
    localparam logic [7:0] StBadSector = 8'hFF;

    localparam logic [PosW-1:0] CmdPos        = 8'd1;
    localparam logic [PosW-1:0] AddrHiPos     = 8'd4;
    localparam logic [PosW-1:0] AddrLoPos     = 8'd5;
    localparam logic [PosW-1:0] DataSendFirst = 8'd6;
    localparam logic [PosW-1:0] CsumPos       = PosW'(6 + SectorBytes);
    localparam logic [PosW-1:0] ReadDataFirst = 8'd10;
    localparam logic [PosW-1:0] ReadDataEnd   = PosW'(10 + SectorBytes);
    localparam logic [PosW-1:0] WriteEndPos   = 8'd137;
    localparam logic [PosW-1:0] ReadEndPos    = 8'd139;
    localparam logic [PosW-1:0] WriteLastPos  = 8'd144;
    localparam logic [PosW-1:0] ReadLastPos   = 8'd147;

    typedef enum logic [1:0] {
        KIND_LOAD        = 2'd0,
        KIND_START_READ  = 2'd1,
        KIND_START_WRITE = 2'd2,
        KIND_CARD        = 2'd3
    } t_kind;

    typedef enum logic [4:0] {
        TX_NONE  = 5'b00001,
        TX_CONST = 5'b00010,
        TX_ADDR  = 5'b00100,
        TX_STORE = 5'b01000,
        TX_CSUM  = 5'b10000
    } t_tx_sel;

    typedef enum logic [1:0] {
        STATUS_GOOD       = 2'd0,
        STATUS_BAD_CSUM   = 2'd1,
        STATUS_BAD_SECTOR = 2'd2,
        STATUS_OTHER      = 2'd3
    } t_status;

    typedef struct packed {
        t_tx_sel         tx_sel;
        logic [7:0]      tx_const;
        logic            clr;
        logic            rd_v;
        logic [IdxW-1:0] rd_idx;
        logic [7:0]      data;
        logic            capture;
        logic            done;
    } t_s1;

    function automatic t_status decode_status(input logic [7:0] e);
        t_status s;
        case (e)
            StGood:      s = STATUS_GOOD;
            StBadCsum:   s = STATUS_BAD_CSUM;
            StBadSector: s = STATUS_BAD_SECTOR;
            default:     s = STATUS_OTHER;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

/* sv/memory_card_frame_sequencer_core.sv */
// ---------------------------------------------------------------------------
// Memory card frame sequencer core
// Builds sector read and write frames byte by byte for a memory card link.
// ---------------------------------------------------------------------------
// One request is taken per clock cycle while the output is not stalled, and
// each request gives exactly one result: the request stage decodes the frame
// position and reads the write data store, the output stage forms the byte
// to send, folds address and data bytes into the checksum and fills the output
// register. Loads and frame bytes share the single store, one access per cycle.
`default_nettype none

module memory_card_frame_sequencer_core
    import mcfs_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    // [15:0] sector_address, [23:16] data_byte
    input  wire logic [IDataW-1:0] i_s_tdata,
    // [1:0] kind
    input  wire logic [1:0]        i_s_tuser,
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    // [7:0] tx_byte, [8] tx_valid, [16:9] read_byte, [17] read_valid,
    // [24:18] read_index, [25] done_res, [33:26] end_byte, [35:34] status_code
    output logic      [ODataW-1:0] o_m_tdata
);

    logic [IdxW-1:0]   r_lc;
    logic [IdxW-1:0]   n_lc;
    logic [PosW-1:0]   r_pos;
    logic [PosW-1:0]   n_pos;
    logic              r_busy;
    logic              n_busy;
    logic              r_wm;
    logic              n_wm;
    logic [15:0]       r_sector;
    logic [15:0]       n_sector;
    t_s1               r_s1;
    t_s1               n_s1;
    logic              r_s1_v;
    logic [7:0]        r_csum;
    logic [7:0]        n_csum;
    logic [7:0]        r_cap;
    logic [7:0]        n_cap;
    logic              r_o_v;
    logic [ODataW-1:0] r_o_data;
    logic [ODataW-1:0] n_o_data;

    logic              accept;
    logic              adv;
    logic              out_free;
    logic              we;
    logic              re;
    logic [IdxW-1:0]   raddr;
    logic [7:0]        rdata;
    logic [PosW-1:0]   np;
    logic [PosW-1:0]   last_pos;
    logic [PosW-1:0]   end_pos;
    logic [15:0]       in_addr;
    logic [7:0]        in_data;
    logic [7:0]        csum_base;
    logic [7:0]        cap_base;
    logic [7:0]        tx_b;
    logic              tx_v;
    t_status           status;

    assign in_addr  = i_s_tdata[15:0];
    assign in_data  = i_s_tdata[23:16];
    assign out_free = !r_o_v || i_m_tready;
    assign adv      = r_s1_v && out_free;
    assign o_s_tready = !r_s1_v || out_free;
    assign accept   = i_s_tvalid && o_s_tready;

    assign np       = r_pos + 8'd1;
    assign last_pos = r_wm ? WriteLastPos : ReadLastPos;
    assign end_pos  = r_wm ? WriteEndPos : ReadEndPos;

    always_comb begin
        n_lc     = r_lc;
        n_pos    = r_pos;
        n_busy   = r_busy;
        n_wm     = r_wm;
        n_sector = r_sector;
        we       = 1'b0;
        re       = 1'b0;
        raddr    = '0;
        n_s1          = '0;
        n_s1.tx_sel   = TX_NONE;
        n_s1.data     = in_data;
        case (t_kind'(i_s_tuser))
            KIND_LOAD: begin
                we   = accept;
                n_lc = r_lc + 1'b1;
            end
            KIND_START_READ, KIND_START_WRITE: begin
                n_busy        = 1'b1;
                n_wm          = (t_kind'(i_s_tuser) == KIND_START_WRITE);
                n_sector      = in_addr;
                n_lc          = '0;
                n_pos         = '0;
                n_s1.tx_sel   = TX_CONST;
                n_s1.tx_const = CardId;
                n_s1.clr      = 1'b1;
            end
            KIND_CARD: begin
                if (r_busy) begin
                    n_s1.rd_v    = !r_wm && (r_pos >= ReadDataFirst) && (r_pos < ReadDataEnd);
                    n_s1.rd_idx  = IdxW'(r_pos - ReadDataFirst);
                    n_s1.capture = (r_pos == end_pos);
                    if (r_pos >= last_pos) begin
                        n_s1.done = 1'b1;
                        n_busy    = 1'b0;
                        n_pos     = '0;
                    end else begin
                        n_pos         = np;
                        n_s1.tx_sel   = TX_CONST;
                        n_s1.tx_const = IdleByte;
                        if (np == CmdPos) begin
                            n_s1.tx_const = r_wm ? CmdWrite : CmdRead;
                        end else if (np == AddrHiPos) begin
                            n_s1.tx_sel   = TX_ADDR;
                            n_s1.tx_const = r_sector[15:8];
                        end else if (np == AddrLoPos) begin
                            n_s1.tx_sel   = TX_ADDR;
                            n_s1.tx_const = r_sector[7:0];
                        end else if (r_wm && np >= DataSendFirst && np < CsumPos) begin
                            n_s1.tx_sel = TX_STORE;
                            re          = accept;
                            raddr       = IdxW'(np - DataSendFirst);
                        end else if (r_wm && np == CsumPos) begin
                            n_s1.tx_sel = TX_CSUM;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    mcfs_store u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_lc),
        .i_wdata (in_data),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        csum_base = r_s1.clr ? 8'h00 : r_csum;
        cap_base  = r_s1.clr ? 8'h00 : r_cap;
        n_csum    = csum_base;
        tx_b      = 8'h00;
        tx_v      = 1'b1;
        case (r_s1.tx_sel)
            TX_NONE: begin
                tx_v = 1'b0;
            end
            TX_CONST: begin
                tx_b = r_s1.tx_const;
            end
            TX_ADDR: begin
                tx_b   = r_s1.tx_const;
                n_csum = csum_base ^ r_s1.tx_const;
            end
            TX_STORE: begin
                tx_b   = rdata;
                n_csum = csum_base ^ rdata;
            end
            TX_CSUM: begin
                tx_b = csum_base;
            end
            default: begin
                tx_v = 1'b0;
            end
        endcase
        n_cap  = r_s1.capture ? r_s1.data : cap_base;
        status = r_s1.done ? decode_status(cap_base) : STATUS_GOOD;
        n_o_data = {4'b0000,
                    status,
                    r_s1.done ? cap_base : 8'h00,
                    r_s1.done,
                    r_s1.rd_v ? r_s1.rd_idx : {IdxW{1'b0}},
                    r_s1.rd_v,
                    r_s1.rd_v ? r_s1.data : 8'h00,
                    tx_v,
                    tx_b};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lc     <= '0;
            r_pos    <= '0;
            r_busy   <= 1'b0;
            r_wm     <= 1'b0;
            r_sector <= '0;
            r_s1_v   <= 1'b0;
            r_csum   <= '0;
            r_cap    <= '0;
            r_o_v    <= 1'b0;
        end else begin
            if (accept) begin
                r_lc     <= n_lc;
                r_pos    <= n_pos;
                r_busy   <= n_busy;
                r_wm     <= n_wm;
                r_sector <= n_sector;
            end
            r_s1_v <= accept || (r_s1_v && !adv);
            if (adv) begin
                r_csum <= n_csum;
                r_cap  <= n_cap;
            end
            r_o_v <= adv || (r_o_v && !i_m_tready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= n_s1;
        end
        if (adv) begin
            r_o_data <= n_o_data;
        end
    end

    assign o_m_tvalid = r_o_v;
    assign o_m_tdata  = r_o_data;

endmodule

`default_nettype wire

/* sv/mcfs_store.sv */
// ---------------------------------------------------------------------------
// Memory card frame sequencer write data store
// One write port and one registered read port over the sector buffer.
// ---------------------------------------------------------------------------
`default_nettype none

module mcfs_store
    import mcfs_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_we,
    input  wire logic [IdxW-1:0] i_waddr,
    input  wire logic [7:0]      i_wdata,
    input  wire logic            i_re,
    input  wire logic [IdxW-1:0] i_raddr,
    output logic      [7:0]      o_rdata
);

    logic [7:0] r_mem [SectorBytes];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* sv/mcfs_checker.sv */
// ---------------------------------------------------------------------------
// Memory card frame sequencer port checker
// Watches the result stream of the sequencer core for consistency.
// ---------------------------------------------------------------------------
`default_nettype none

`include "memory_card_frame_sequencer_core_defines.svh"

module mcfs_checker
    import mcfs_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_s_tvalid,
    input wire logic              o_s_tready,
    input wire logic [IDataW-1:0] i_s_tdata,
    input wire logic [1:0]        i_s_tuser,
    input wire logic              o_m_tvalid,
    input wire logic              i_m_tready,
    input wire logic [ODataW-1:0] o_m_tdata
);

    logic       in_req;
    logic       tx_v;
    logic       rd_v;
    logic       done;
    logic [7:0] end_b;
    logic [1:0] st;

    assign in_req = i_s_tvalid && o_s_tready && (i_s_tdata[0] || !i_s_tdata[0])
                    && (i_s_tuser[0] || !i_s_tuser[0]);
    assign tx_v  = o_m_tdata[8];
    assign rd_v  = o_m_tdata[17];
    assign done  = o_m_tdata[25];
    assign end_b = o_m_tdata[33:26];
    assign st    = o_m_tdata[35:34];

    `MCFS_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata), "Stalled result request changed.")
    `MCFS_ASSERT_NOW(a_done_alone, i_clk, i_rst_n, o_m_tvalid && done, !tx_v && !rd_v, "Frame end result also sends or forwards a byte.")
    `MCFS_ASSERT_NOW(a_status, i_clk, i_rst_n, o_m_tvalid && done, st == 2'(decode_status(end_b)), "Status does not match the end byte.")
    `MCFS_ASSERT_NOW(a_quiet, i_clk, i_rst_n, o_m_tvalid && !done, end_b == 8'h00 && st == 2'(STATUS_GOOD), "End fields set without frame end.")
    `MCFS_ASSERT_NEXT(a_after_req, i_clk, i_rst_n, in_req && !o_m_tvalid, !o_m_tvalid || o_m_tdata[39:36] == 4'h0, "Result padding is not zero.")

endmodule

bind memory_card_frame_sequencer_core mcfs_checker u_mcfs_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

`default_nettype wire
